### rtl/adsr_pkg.sv
// Shared types and constants for the ADSR envelope generator.
package adsr_pkg;

  localparam int SAMPLE_RATE_HZ = 48000;
  localparam int SR_W           = 18;   // holds sample rates up to 192 kHz
  localparam int MSEC_PER_SEC   = 1000;
  localparam int MSEC_W         = 10;
  localparam int LVL_W          = 16;
  localparam int MS_W           = 16;
  localparam int CNT_W          = 32;
  localparam int CFG_W          = 16;
  localparam int CFG_IDX_W      = 2;
  localparam int PROD_W         = LVL_W + CNT_W;
  localparam int NUM_W          = PROD_W + MSEC_W;
  localparam int NUMT_W         = CNT_W + MSEC_W;
  localparam int DEN_W          = MS_W + SR_W;
  localparam int Q_W            = LVL_W + 1;
  localparam int DIV_CNT_W      = $clog2(Q_W);

  localparam logic [LVL_W-1:0] FULL_SCALE = LVL_W'(32768);

  localparam logic [MS_W-1:0]  ATTACK_MS_RST     = MS_W'(200);
  localparam logic [MS_W-1:0]  DECAY_MS_RST      = MS_W'(5000);
  localparam logic [LVL_W-1:0] SUSTAIN_LEVEL_RST = LVL_W'(16384);
  localparam logic [MS_W-1:0]  RELEASE_MS_RST    = MS_W'(500);

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_ATTACK  = 3'd1,
    PH_DECAY   = 3'd2,
    PH_SUSTAIN = 3'd3,
    PH_RELEASE = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_NOTE_ON  = 2'd1,
    OP_NOTE_OFF = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ATTACK_MS     = 2'd0,
    CFG_DECAY_MS      = 2'd1,
    CFG_SUSTAIN_LEVEL = 2'd2,
    CFG_RELEASE_MS    = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL1,
    ST_MUL2,
    ST_DIVINIT,
    ST_DIV,
    ST_FIN
  } ctrl_state_t;

  typedef struct packed {
    logic [MS_W-1:0]  attack_ms;
    logic [MS_W-1:0]  decay_ms;
    logic [LVL_W-1:0] sustain_level;
    logic [MS_W-1:0]  release_ms;
  } cfg_t;

  typedef struct packed {
    logic ld_in;
    logic prep;
    logic mul1;
    logic mul2;
    logic div_init;
    logic div_step;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic interp_req;
    logic div_last;
  } dp_sts_t;

endpackage

### rtl/adsr_ctrl.sv
// Sequencing state machine for the ADSR envelope generator.
module adsr_ctrl import adsr_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_PREP;
      end
      ST_PREP: begin
        state_nxt = sts.interp_req ? ST_MUL1 : ST_FIN;
      end
      ST_MUL1:    state_nxt = ST_MUL2;
      ST_MUL2:    state_nxt = ST_DIVINIT;
      ST_DIVINIT: state_nxt = ST_DIV;
      ST_DIV: begin
        if (sts.div_last) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    in_ready     = (state_r == ST_IDLE);
    cmd.ld_in    = in_valid && (state_r == ST_IDLE);
    cmd.prep     = (state_r == ST_PREP);
    cmd.mul1     = (state_r == ST_MUL1);
    cmd.mul2     = (state_r == ST_MUL2);
    cmd.div_init = (state_r == ST_DIVINIT);
    cmd.div_step = (state_r == ST_DIV);
    cmd.commit   = (state_r == ST_FIN) && slot_free;
  end

  // result beat stays until taken; a new one loads only into a free slot
  always_comb begin
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### rtl/adsr_dp.sv
// Envelope state, interpolation arithmetic and serial divider.
module adsr_dp import adsr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  dp_cmd_t          cmd,
  output dp_sts_t          sts,
  input  cfg_t             cfg,
  input  logic [1:0]       in_operation,
  input  logic [LVL_W-1:0] in_velocity,
  output logic [LVL_W-1:0] out_level,
  output logic [2:0]       out_phase
);

  // envelope state
  phase_t           phase_r, phase_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [LVL_W-1:0] level_r, level_nxt;
  logic [LVL_W-1:0] peak_r, peak_nxt;
  logic [LVL_W-1:0] rel_start_r, rel_start_nxt;

  // per-item working registers
  logic [1:0]           op_r;
  logic [LVL_W-1:0]     vel_r;
  logic [CNT_W-1:0]     n_new_r;
  logic [LVL_W-1:0]     sus_r;
  logic [PROD_W-1:0]    prod_r;
  logic [NUMT_W-1:0]    numt_r;
  logic [DEN_W-1:0]     den_r;
  logic [NUM_W-1:0]     num_r;
  logic                 done_r;
  logic                 ovf_r;
  logic [DEN_W-1:0]     rem_r;
  logic [Q_W-1:0]       lo_r;
  logic [Q_W-1:0]       q_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [LVL_W-1:0]     out_level_r;
  phase_t               out_phase_r;

  logic [LVL_W-1:0]   from_lvl, to_lvl, delta;
  logic [MS_W-1:0]    dur;
  logic               up;
  logic [2*LVL_W-1:0] sus_prod;
  logic [DEN_W:0]     rem_sh;
  logic               rem_ge;
  logic [Q_W-1:0]     headroom;
  logic [LVL_W-1:0]   lvl_i;
  logic               fin_i;

  always_comb begin
    case (phase_r)
      PH_ATTACK: begin
        from_lvl = '0;
        to_lvl   = peak_r;
        dur      = cfg.attack_ms;
      end
      PH_DECAY: begin
        from_lvl = peak_r;
        to_lvl   = sus_r;
        dur      = cfg.decay_ms;
      end
      PH_RELEASE: begin
        from_lvl = rel_start_r;
        to_lvl   = '0;
        dur      = cfg.release_ms;
      end
      default: begin
        from_lvl = '0;
        to_lvl   = '0;
        dur      = '0;
      end
    endcase
  end

  assign up    = (to_lvl >= from_lvl);
  assign delta = up ? (to_lvl - from_lvl) : (from_lvl - to_lvl);

  assign sus_prod = (2*LVL_W)'(cfg.sustain_level) * (2*LVL_W)'(peak_r);

  assign sts.interp_req = (op_r == OP_TICK) && (dur != '0) &&
                          ((phase_r == PH_ATTACK) || (phase_r == PH_DECAY) ||
                           (phase_r == PH_RELEASE));
  assign sts.div_last   = (div_cnt_r == DIV_CNT_W'(Q_W - 1));

  // restoring divide, one quotient bit per step
  assign rem_sh = {rem_r, lo_r[Q_W-1]};
  assign rem_ge = (rem_sh >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      op_r  <= in_operation;
      vel_r <= in_velocity;
    end
    if (cmd.prep) begin
      n_new_r <= (cnt_r == '1) ? cnt_r : cnt_r + CNT_W'(1);
      sus_r   <= sus_prod[LVL_W +: LVL_W] << 1 | LVL_W'(sus_prod[LVL_W-1]);
    end
    if (cmd.mul1) begin
      prod_r <= PROD_W'(delta) * PROD_W'(n_new_r);
      numt_r <= NUMT_W'(n_new_r) * NUMT_W'(MSEC_PER_SEC);
      den_r  <= DEN_W'(dur) * DEN_W'(SAMPLE_RATE_HZ);
    end
    if (cmd.mul2) begin
      num_r  <= NUM_W'(prod_r) * NUM_W'(MSEC_PER_SEC);
      done_r <= (numt_r >= NUMT_W'(den_r));
    end
    if (cmd.div_init) begin
      // a quotient that does not fit Q_W bits always clamps
      ovf_r     <= (num_r >= NUM_W'({den_r, {Q_W{1'b0}}}));
      rem_r     <= num_r[Q_W +: DEN_W];
      lo_r      <= num_r[Q_W-1:0];
      q_r       <= '0;
      div_cnt_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r     <= rem_ge ? DEN_W'(rem_sh - {1'b0, den_r}) : rem_sh[DEN_W-1:0];
      lo_r      <= {lo_r[Q_W-2:0], 1'b0};
      q_r       <= {q_r[Q_W-2:0], rem_ge};
      div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
    end
    if (cmd.commit) begin
      out_level_r <= level_nxt;
      out_phase_r <= phase_nxt;
    end
  end

  assign headroom = Q_W'(FULL_SCALE) - Q_W'(from_lvl);

  always_comb begin
    if (dur == '0) begin
      lvl_i = to_lvl;
      fin_i = 1'b1;
    end else if (up) begin
      if (ovf_r || (q_r > headroom)) begin
        lvl_i = FULL_SCALE;
        fin_i = 1'b1;
      end else begin
        lvl_i = from_lvl + q_r[LVL_W-1:0];
        fin_i = done_r;
      end
    end else begin
      if (ovf_r || (q_r > Q_W'(from_lvl))) begin
        lvl_i = '0;
        fin_i = 1'b1;
      end else begin
        lvl_i = from_lvl - q_r[LVL_W-1:0];
        fin_i = done_r;
      end
    end
  end

  always_comb begin
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    level_nxt     = level_r;
    peak_nxt      = peak_r;
    rel_start_nxt = rel_start_r;
    case (op_r)
      OP_TICK: begin
        cnt_nxt = n_new_r;
        case (phase_r)
          PH_ATTACK: begin
            level_nxt = lvl_i;
            if (fin_i) begin
              cnt_nxt   = '0;
              phase_nxt = PH_DECAY;
            end
          end
          PH_DECAY: begin
            level_nxt = lvl_i;
            if (fin_i) begin
              cnt_nxt   = '0;
              phase_nxt = PH_SUSTAIN;
            end
            if (lvl_i == '0) phase_nxt = PH_IDLE;
          end
          PH_RELEASE: begin
            level_nxt = lvl_i;
            if (fin_i) phase_nxt = PH_IDLE;
          end
          default: ;
        endcase
      end
      OP_NOTE_ON: begin
        phase_nxt = PH_ATTACK;
        peak_nxt  = (vel_r > FULL_SCALE) ? FULL_SCALE : vel_r;
        cnt_nxt   = '0;
        level_nxt = '0;
      end
      OP_NOTE_OFF: begin
        if (phase_r != PH_IDLE) begin
          phase_nxt     = PH_RELEASE;
          cnt_nxt       = '0;
          rel_start_nxt = level_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      cnt_r       <= '0;
      level_r     <= '0;
      peak_r      <= '0;
      rel_start_r <= '0;
    end else if (cmd.commit) begin
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      level_r     <= level_nxt;
      peak_r      <= peak_nxt;
      rel_start_r <= rel_start_nxt;
    end
  end

  assign out_level = out_level_r;
  assign out_phase = out_phase_r;

endmodule

### rtl/adsr_envelope_generator_core.sv
// Top level of the linear ADSR envelope generator.
// Input channel (in_valid/in_ready): each beat is a sample tick, a note-on
// carrying in_velocity, or a note-off. Every input beat yields exactly one
// result beat on the output channel (out_valid/out_ready) with the updated
// level (Q1.15) and phase.
// A tick in attack, decay or release with a nonzero phase time runs two
// multiply stages and a 17-step restoring divider; all other items skip
// them. The next input beat is accepted only after the current result has
// been committed to the output register.
// The output register holds a result until it is taken; the next input beat
// is accepted meanwhile and waits in its final step while out_ready is low.
// cfg_we writes register cfg_index (0 attack_ms, 1 decay_ms, 2 sustain_level,
// 3 release_ms) from cfg_wdata in the same cycle; sustain saturates at 1.0.
// Synchronous reset (rst_n low) loads the default times and levels, puts the
// envelope in idle at level zero and drops any pending result.
module adsr_envelope_generator_core import adsr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_operation,
  input  logic [LVL_W-1:0]     in_velocity,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [LVL_W-1:0]     out_level,
  output logic [2:0]           out_phase,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  cfg_t    cfg_r, cfg_nxt;
  dp_cmd_t cmd;
  dp_sts_t sts;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_ATTACK_MS:     cfg_nxt.attack_ms  = cfg_wdata;
        CFG_DECAY_MS:      cfg_nxt.decay_ms   = cfg_wdata;
        CFG_SUSTAIN_LEVEL: cfg_nxt.sustain_level =
                             (cfg_wdata > FULL_SCALE) ? FULL_SCALE : cfg_wdata;
        CFG_RELEASE_MS:    cfg_nxt.release_ms = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.attack_ms     <= ATTACK_MS_RST;
      cfg_r.decay_ms      <= DECAY_MS_RST;
      cfg_r.sustain_level <= SUSTAIN_LEVEL_RST;
      cfg_r.release_ms    <= RELEASE_MS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  adsr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  adsr_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .cfg          (cfg_r),
    .in_operation (in_operation),
    .in_velocity  (in_velocity),
    .out_level    (out_level),
    .out_phase    (out_phase)
  );

endmodule

### tb/tb_adsr_envelope_generator_core.sv
// Self-checking testbench for the ADSR envelope generator core.
module tb_adsr_envelope_generator_core;
  import adsr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int              CYCLE_LIMIT   = 600000;
  localparam int              SETTLE_CYCLES = 6;
  localparam logic [1:0]      OP_UNUSED     = 2'd3;

  typedef struct {
    logic [LVL_W-1:0] level;
    phase_t           phase;
  } env_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           in_operation = OP_TICK;
  logic [LVL_W-1:0]     in_velocity = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [LVL_W-1:0]     out_level;
  logic [2:0]           out_phase;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_ATTACK_MS;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  // envelope state as the block should hold it
  phase_t           m_phase;
  logic [CNT_W-1:0] m_count;
  logic [LVL_W-1:0] m_level;
  logic [LVL_W-1:0] m_peak;
  logic [LVL_W-1:0] m_rel_start;
  logic [MS_W-1:0]  m_attack_ms;
  logic [MS_W-1:0]  m_decay_ms;
  logic [LVL_W-1:0] m_sustain;
  logic [MS_W-1:0]  m_release_ms;

  env_result_t pending_env[$];
  int          errors = 0;
  int          items_sent = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          hold_left = 0;

  adsr_envelope_generator_core u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_velocity  (in_velocity),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_level    (out_level),
    .out_phase    (out_phase),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side: random stalls, plus a counted hold-off when one is requested
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else begin
      out_ready = ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    env_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_env.size() == 0) begin
        $display("%0t: unexpected beat, got level %0d phase %0d",
                 $time, out_level, out_phase);
        errors++;
      end else begin
        want = pending_env.pop_front();
        if (out_level !== want.level) begin
          $display("%0t: level mismatch, expected %0d got %0d",
                   $time, want.level, out_level);
          errors++;
        end
        if (out_phase !== want.phase) begin
          $display("%0t: phase mismatch, expected %0d got %0d",
                   $time, want.phase, out_phase);
          errors++;
        end
      end
    end
  end

  function automatic void envelope_reset();
    m_phase      = PH_IDLE;
    m_count      = '0;
    m_level      = '0;
    m_peak       = '0;
    m_rel_start  = '0;
    m_attack_ms  = ATTACK_MS_RST;
    m_decay_ms   = DECAY_MS_RST;
    m_sustain    = SUSTAIN_LEVEL_RST;
    m_release_ms = RELEASE_MS_RST;
  endfunction

  // linear ramp from from_lvl toward to_lvl; updates m_level, 1 when the segment ends
  function automatic bit ramp(input logic [LVL_W-1:0] from_lvl,
                              input logic [LVL_W-1:0] to_lvl,
                              input logic [MS_W-1:0]  dur_ms);
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] elapsed;
    logic [63:0] span;
    logic [63:0] gap;
    logic [63:0] step;
    longint      lvl;
    if (dur_ms == '0) begin
      m_level = to_lvl;
      return 1'b1;
    end
    a       = 64'(from_lvl);
    b       = 64'(to_lvl);
    elapsed = 64'(m_count) * 64'd1000;
    span    = 64'(SAMPLE_RATE_HZ) * 64'(dur_ms);
    gap     = (b >= a) ? b - a : a - b;
    step    = (gap * elapsed) / span;
    lvl     = (b >= a) ? longint'(a + step) : longint'(a) - longint'(step);
    if (lvl < 0) begin
      m_level = '0;
      return 1'b1;
    end
    if (lvl > longint'(FULL_SCALE)) begin
      m_level = FULL_SCALE;
      return 1'b1;
    end
    m_level = lvl[LVL_W-1:0];
    return elapsed >= span;
  endfunction

  function automatic void advance_tick();
    logic [31:0] sus_full;
    if (m_count != '1) m_count = m_count + CNT_W'(1);
    case (m_phase)
      PH_ATTACK: begin
        if (ramp('0, m_peak, m_attack_ms)) begin
          m_count = '0;
          m_phase = PH_DECAY;
        end
      end
      PH_DECAY: begin
        sus_full = (32'(m_sustain) * 32'(m_peak)) >> 15;
        if (ramp(m_peak, sus_full[LVL_W-1:0], m_decay_ms)) begin
          m_count = '0;
          m_phase = PH_SUSTAIN;
        end
        if (m_level == '0) m_phase = PH_IDLE;
      end
      PH_RELEASE: begin
        if (ramp(m_rel_start, '0, m_release_ms)) m_phase = PH_IDLE;
      end
      default: ;
    endcase
  endfunction

  function automatic void envelope_step(input logic [1:0] op, input logic [LVL_W-1:0] vel);
    env_result_t r;
    case (op)
      OP_TICK: advance_tick();
      OP_NOTE_ON: begin
        m_phase = PH_ATTACK;
        m_peak  = (vel > FULL_SCALE) ? FULL_SCALE : vel;
        m_count = '0;
        m_level = '0;
      end
      OP_NOTE_OFF: begin
        if (m_phase != PH_IDLE) begin
          m_phase     = PH_RELEASE;
          m_count     = '0;
          m_rel_start = m_level;
        end
      end
      default: ;
    endcase
    r.level = m_level;
    r.phase = m_phase;
    pending_env.push_back(r);
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_beat(input logic [1:0] op, input logic [LVL_W-1:0] vel);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    in_operation = op;
    in_velocity  = vel;
    do @(posedge clk); while (!in_ready);
    envelope_step(op, vel);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid = 1'b0;
    while (pending_env.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    case (idx)
      CFG_ATTACK_MS:     m_attack_ms  = value;
      CFG_DECAY_MS:      m_decay_ms   = value;
      CFG_SUSTAIN_LEVEL: m_sustain    = (value > FULL_SCALE) ? FULL_SCALE : value;
      CFG_RELEASE_MS:    m_release_ms = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic apply_settings(input logic [MS_W-1:0] atk, input logic [MS_W-1:0] dec,
                                input logic [LVL_W-1:0] sus, input logic [MS_W-1:0] rel);
    settle();
    write_reg(CFG_ATTACK_MS, atk);
    write_reg(CFG_DECAY_MS, dec);
    write_reg(CFG_SUSTAIN_LEVEL, sus);
    write_reg(CFG_RELEASE_MS, rel);
  endtask

  // mostly 1-2 ms so segments finish within a note; extremes now and then
  function automatic logic [MS_W-1:0] pick_ms();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return MS_W'($urandom);
      default: return MS_W'($urandom_range(1, 2));
    endcase
  endfunction

  function automatic logic [LVL_W-1:0] pick_sustain();
    case ($urandom_range(5))
      0:       return '0;
      1:       return FULL_SCALE;
      2:       return '1;
      3:       return LVL_W'($urandom);
      default: return LVL_W'($urandom_range(0, 32768));
    endcase
  endfunction

  function automatic logic [LVL_W-1:0] pick_velocity();
    case ($urandom_range(9))
      0:       return '0;
      1:       return LVL_W'(1);
      2:       return FULL_SCALE;
      3:       return '1;
      4:       return LVL_W'($urandom);
      default: return LVL_W'($urandom_range(1, 32768));
    endcase
  endfunction

  task automatic run_notes(input int n);
    int target;
    target = items_sent + n;
    while (items_sent < target) begin
      if ($urandom_range(9) == 0) begin
        // noise: any op code, any velocity bits
        repeat ($urandom_range(1, 6)) send_beat(2'($urandom), LVL_W'($urandom));
      end else begin
        send_beat(OP_NOTE_ON, pick_velocity());
        repeat ($urandom_range(0, 100)) send_beat(OP_TICK, LVL_W'($urandom));
        if ($urandom_range(3) != 0) send_beat(OP_NOTE_OFF, LVL_W'($urandom));
        repeat ($urandom_range(0, 80)) send_beat(OP_TICK, LVL_W'($urandom));
      end
    end
  endtask

  task automatic test_reset_defaults();
    send_beat(OP_TICK, '0);
    send_beat(OP_NOTE_OFF, '0);
    send_beat(OP_UNUSED, '1);
    send_beat(OP_NOTE_ON, '1);           // saturates to full scale
    repeat (3) send_beat(OP_TICK, '0);
    send_beat(OP_NOTE_OFF, '0);
    repeat (2) send_beat(OP_TICK, '0);
    send_beat(OP_NOTE_ON, LVL_W'(1));
    send_beat(OP_TICK, '0);
  endtask

  task automatic test_instant_phases();
    apply_settings('0, '0, '1, '0);
    // zero velocity: attack ends at zero, decay drops to idle
    send_beat(OP_NOTE_ON, '0);
    repeat (2) send_beat(OP_TICK, '0);
    send_beat(OP_NOTE_ON, FULL_SCALE);
    repeat (3) send_beat(OP_TICK, '0);
    send_beat(OP_NOTE_OFF, '0);
    send_beat(OP_TICK, '0);
  endtask

  task automatic test_notes_random(input int idle_pct, input int stall);
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    repeat (4) begin
      apply_settings(pick_ms(), pick_ms(), pick_sustain(), pick_ms());
      run_notes(30);
    end
  endtask

  task automatic test_stall_then_pause();
    apply_settings(MS_W'(1), '1, FULL_SCALE, '0);
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_left     = 300;
    send_beat(OP_NOTE_ON, FULL_SCALE);
    repeat (40) send_beat(OP_TICK, LVL_W'($urandom));
    settle();
    send_beat(OP_NOTE_OFF, '0);
    repeat (20) send_beat(OP_TICK, LVL_W'($urandom));
    send_beat(OP_NOTE_ON, LVL_W'($urandom_range(1, 32768)));
    repeat (20) send_beat(OP_TICK, LVL_W'($urandom));
  endtask

  initial begin
    envelope_reset();
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    test_reset_defaults();
    test_instant_phases();
    test_notes_random(0, 0);
    test_notes_random(57, 0);
    test_notes_random(0, 57);
    test_notes_random(33, 33);
    test_stall_then_pause();
    settle();
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
